/* design/awdf_pkg.sv */
// ----------------------------------------------------------------------------
// ACL wildcard drop filter package
// Shared widths, codes and the rule-table record types of the filter.
// ----------------------------------------------------------------------------
package awdf_pkg;

  // Number of rule slots and the width of a slot index.
  localparam int RULES = 16;
  localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;

  // Stream widths: fields packed from bit 0 upward, tdata padded to whole bytes.
  localparam int IN_TDATA_W  = 104;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;

  // EtherType that the filter inspects.
  localparam logic [15:0] IPV4_KIND = 16'h0800;

  // Command codes carried in the input tuser.
  localparam logic [1:0] CMD_CHECK    = 2'd0;
  localparam logic [1:0] CMD_WRITE    = 2'd1;
  localparam logic [1:0] CMD_ACTIVATE = 2'd2;

  // Action code of a drop rule.
  localparam logic [1:0] ACT_DROP = 2'd0;

  // One stored rule.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic        src_any;
    logic        dst_any;
    logic        proto_any;
    logic        is_drop;
  } rule_t;

  // Write and activate request into the rule table.
  typedef struct packed {
    logic             wr_en;
    logic             act_en;
    logic [IDX_W-1:0] idx;
    rule_t            rule;
  } tbl_req_t;

endpackage

/* design/awdf_rule_table.sv */
// ----------------------------------------------------------------------------
// ACL rule table
// Rule memory with one write port and one registered read port, plus the
// per-slot active flags that reset clears.
// ----------------------------------------------------------------------------
module awdf_rule_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  awdf_pkg::tbl_req_t           req,
  input  logic                         rd_en,
  input  logic [awdf_pkg::IDX_W-1:0]   rd_addr,
  output awdf_pkg::rule_t              rd_rule,
  output logic                         rd_active
);

  awdf_pkg::rule_t             mem [awdf_pkg::RULES];
  logic [awdf_pkg::RULES-1:0]  active_r;
  awdf_pkg::rule_t             rd_rule_r;
  logic                        rd_active_r;

  // Rule storage: no reset, entries are defined once written.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.idx] <= req.rule;
    end
    if (rd_en) begin
      rd_rule_r <= mem[rd_addr];
    end
  end

  // Active flags: a rewrite deactivates the slot, activate sets it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      rd_active_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        active_r[req.idx] <= 1'b0;
      end else if (req.act_en) begin
        active_r[req.idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_active_r <= active_r[rd_addr];
      end
    end
  end

  assign rd_rule   = rd_rule_r;
  assign rd_active = rd_active_r;

endmodule

/* design/acl_wildcard_drop_filter.sv */
// ----------------------------------------------------------------------------
// ACL wildcard drop filter
// Stores up to RULES wildcard rules and drops IPv4 packets that hit an active
// drop rule, keeping a saturating count of dropped packets.
// ----------------------------------------------------------------------------
// An IPv4 packet check goes from idle to the scan, which stops at the first hit
// or after the last slot, and then to the result state; every other request
// goes straight to the result state. A new request is taken only once the last
// result is registered; the scan reads one rule a cycle from the table port.
// Reset (rst_n low, synchronous) clears the active flags, the drop count,
// the sequencer and the output valid flag; rule contents are kept.
// ----------------------------------------------------------------------------
module acl_wildcard_drop_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: rule_index[3:0], src_addr[35:4], dst_addr[67:36],
  // ip_protocol[75:68], ether_kind[91:76], src_any[92], dst_any[93],
  // proto_any[94], action_code[96:95], zero pad[103:97]
  input  logic [awdf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: command[1:0]
  input  logic [awdf_pkg::IN_TUSER_W-1:0]    in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: drop[0], dropped_total[32:1], zero pad[39:33]
  output logic [awdf_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  localparam int PTR_W = $clog2(awdf_pkg::RULES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic               fin_drop_r, fin_drop_nxt;
  logic [31:0]        drop_cnt_r, drop_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_drop_r, out_drop_nxt;
  logic [31:0]        out_total_r, out_total_nxt;
  logic [31:0]        pkt_src_r, pkt_dst_r;
  logic [7:0]         pkt_proto_r;

  // Input field unpacking.
  logic [1:0]  in_command;
  logic [3:0]  in_rule_index;
  logic [31:0] in_src_addr;
  logic [31:0] in_dst_addr;
  logic [7:0]  in_ip_protocol;
  logic [15:0] in_ether_kind;
  logic        in_src_any;
  logic        in_dst_any;
  logic        in_proto_any;
  logic [1:0]  in_action_code;
  logic        in_accept;
  logic        slot_ok;

  assign in_command     = in_tuser[1:0];
  assign in_rule_index  = in_tdata[3:0];
  assign in_src_addr    = in_tdata[35:4];
  assign in_dst_addr    = in_tdata[67:36];
  assign in_ip_protocol = in_tdata[75:68];
  assign in_ether_kind  = in_tdata[91:76];
  assign in_src_any     = in_tdata[92];
  assign in_dst_any     = in_tdata[93];
  assign in_proto_any   = in_tdata[94];
  assign in_action_code = in_tdata[96:95];

  // No request is taken while reset is held.
  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign slot_ok   = (32'(in_rule_index) < 32'(awdf_pkg::RULES));

  // Rule table.
  awdf_pkg::tbl_req_t tbl_req;
  logic               rd_en;
  awdf_pkg::rule_t    rd_rule;
  logic               rd_active;

  awdf_rule_table u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (tbl_req),
    .rd_en     (rd_en),
    .rd_addr   (rd_ptr_r[awdf_pkg::IDX_W-1:0]),
    .rd_rule   (rd_rule),
    .rd_active (rd_active)
  );

  // Shared compare unit: one rule against the latched packet.
  logic rule_hit;
  logic scan_hit;
  logic scan_done;

  assign rule_hit = rd_active && rd_rule.is_drop &&
                    (rd_rule.src_any   || (rd_rule.src   == pkt_src_r)) &&
                    (rd_rule.dst_any   || (rd_rule.dst   == pkt_dst_r)) &&
                    (rd_rule.proto_any || (rd_rule.proto == pkt_proto_r));
  assign scan_hit  = cmp_vld_r && rule_hit;
  assign scan_done = cmp_vld_r &&
                     (rule_hit || (rd_ptr_r == PTR_W'(awdf_pkg::RULES)));

  // Sequencer and result logic.
  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    cmp_vld_nxt   = 1'b0;
    fin_drop_nxt  = fin_drop_r;
    drop_cnt_nxt  = drop_cnt_r;
    out_valid_nxt = out_valid_r;
    out_drop_nxt  = out_drop_r;
    out_total_nxt = out_total_r;
    rd_en         = 1'b0;

    tbl_req.wr_en          = 1'b0;
    tbl_req.act_en         = 1'b0;
    tbl_req.idx            = awdf_pkg::IDX_W'(in_rule_index);
    tbl_req.rule.src       = in_src_addr;
    tbl_req.rule.dst       = in_dst_addr;
    tbl_req.rule.proto     = in_ip_protocol;
    tbl_req.rule.src_any   = in_src_any;
    tbl_req.rule.dst_any   = in_dst_any;
    tbl_req.rule.proto_any = in_proto_any;
    tbl_req.rule.is_drop   = (in_action_code == awdf_pkg::ACT_DROP);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          fin_drop_nxt = 1'b0;
          state_nxt    = S_FIN;
          case (in_command)
            awdf_pkg::CMD_CHECK: begin
              if (in_ether_kind == awdf_pkg::IPV4_KIND) begin
                state_nxt  = S_SCAN;
                rd_ptr_nxt = '0;
              end
            end
            awdf_pkg::CMD_WRITE: begin
              tbl_req.wr_en = slot_ok;
            end
            awdf_pkg::CMD_ACTIVATE: begin
              tbl_req.act_en = slot_ok;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_nxt    = S_FIN;
          fin_drop_nxt = scan_hit;
          if (scan_hit && (drop_cnt_r != 32'hFFFF_FFFF)) begin
            drop_cnt_nxt = drop_cnt_r + 32'd1;
          end
        end else if (rd_ptr_r < PTR_W'(awdf_pkg::RULES)) begin
          rd_en       = 1'b1;
          rd_ptr_nxt  = rd_ptr_r + PTR_W'(1);
          cmp_vld_nxt = 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_drop_nxt  = fin_drop_r;
          out_total_nxt = drop_cnt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      drop_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      drop_cnt_r  <= drop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_ptr_r    <= rd_ptr_nxt;
    fin_drop_r  <= fin_drop_nxt;
    out_drop_r  <= out_drop_nxt;
    out_total_r <= out_total_nxt;
    if (in_accept) begin
      pkt_src_r   <= in_src_addr;
      pkt_dst_r   <= in_dst_addr;
      pkt_proto_r <= in_ip_protocol;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_total_r, out_drop_r};

  // A compare is only pending while the scan runs.
  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == S_SCAN))
    else $error("compare pending outside the scan");

  // Each accepted request makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("request accepted while the previous one is in progress");

  // The drop count never goes down.
  a_cnt_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (drop_cnt_r >= $past(drop_cnt_r)))
    else $error("drop count decreased");

endmodule

/* test/tb_acl_wildcard_drop_filter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ACL wildcard drop filter testbench
// Drives packet-check, rule-write, rule-activate and unused requests into the
// filter with random gaps, stalls the result side at random, and checks each
// result against its directed row's typed-in value or a testbench model of the
// rule table. A short directed pass covers edge cases; a long random one follows.
// ----------------------------------------------------------------------------
module tb_acl_wildcard_drop_filter;

  // Codes that the package does not name.
  localparam logic [1:0] CMD_NOP      = 2'd3;
  localparam logic [1:0] ACT_RATE     = 2'd1;
  localparam logic [1:0] ACT_REDIRECT = 2'd2;
  localparam logic [1:0] ACT_BAD      = 2'd3;

  localparam int          DIR_ROWS    = 25;
  localparam int          RAND_ITEMS  = 1425;
  localparam int          EXP_DEPTH   = 64;
  localparam int unsigned CYCLE_LIMIT = 600000;

  // One request as the filter sees it.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  idx;
    logic [31:0] src;
    logic [31:0] dst;
    logic [7:0]  proto;
    logic [15:0] kind;
    logic        s_any;
    logic        d_any;
    logic        p_any;
    logic [1:0]  act;
  } req_t;

  // One result of the filter.
  typedef struct packed {
    logic        drop;
    logic [31:0] total;
  } verdict_t;

  // One directed row, with the result typed in where it is obvious.
  typedef struct packed {
    req_t     rq;
    logic     typed;
    verdict_t want;
  } row_t;

  logic                             clk;
  logic                             rst_n     = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [awdf_pkg::IN_TDATA_W-1:0]  in_tdata  = '0;
  logic [awdf_pkg::IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [awdf_pkg::OUT_TDATA_W-1:0] out_tdata;

  // Side information that travels with the request on the bus.
  req_t     cur_req   = '0;
  logic     cur_typed = 1'b0;
  verdict_t cur_want  = '0;

  // Rule table as the filter should hold it.
  logic [31:0] slot_src   [awdf_pkg::RULES];
  logic [31:0] slot_dst   [awdf_pkg::RULES];
  logic [7:0]  slot_proto [awdf_pkg::RULES];
  logic [2:0]  slot_wild  [awdf_pkg::RULES];
  logic        slot_drops [awdf_pkg::RULES];
  logic        slot_live  [awdf_pkg::RULES];
  logic [31:0] drop_total;

  // What the sender has issued so far, used to shape the random requests.
  logic        plan_written [awdf_pkg::RULES];
  logic        plan_live    [awdf_pkg::RULES];
  logic [31:0] plan_src     [awdf_pkg::RULES];
  logic [31:0] plan_dst     [awdf_pkg::RULES];
  logic [7:0]  plan_proto   [awdf_pkg::RULES];
  logic [2:0]  plan_wild    [awdf_pkg::RULES];

  // Expected results in request order, as a ring with running counts.
  verdict_t    exp_mem [EXP_DEPTH];
  logic [31:0] exp_wr      = '0;
  logic [31:0] exp_rd      = '0;
  int unsigned fail_count  = 0;
  int unsigned cycles      = 0;
  logic        sender_calm = 1'b0;
  row_t        dir_tab [DIR_ROWS];

  acl_wildcard_drop_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one request to the table model and returns the drop decision.
  function automatic logic acl_verdict(input req_t r);
    logic hit;
    hit = 1'b0;
    case (r.cmd)
      awdf_pkg::CMD_CHECK: begin
        if (r.kind == awdf_pkg::IPV4_KIND) begin
          for (int k = 0; k < awdf_pkg::RULES; k++) begin
            if (slot_live[k] && slot_drops[k] &&
                (slot_wild[k][0] || slot_src[k] == r.src) &&
                (slot_wild[k][1] || slot_dst[k] == r.dst) &&
                (slot_wild[k][2] || slot_proto[k] == r.proto)) begin
              hit = 1'b1;
              break;
            end
          end
          // The count saturates; a packet counts once however many rules hit.
          if (hit && drop_total != 32'hFFFF_FFFF) drop_total = drop_total + 32'd1;
        end
      end
      awdf_pkg::CMD_WRITE: begin
        slot_src[r.idx]   = r.src;
        slot_dst[r.idx]   = r.dst;
        slot_proto[r.idx] = r.proto;
        slot_wild[r.idx]  = {r.p_any, r.d_any, r.s_any};
        slot_drops[r.idx] = (r.act == awdf_pkg::ACT_DROP);
        slot_live[r.idx]  = 1'b0;
      end
      awdf_pkg::CMD_ACTIVATE: begin
        slot_live[r.idx] = 1'b1;
      end
      default: begin
      end
    endcase
    return hit;
  endfunction

  function automatic row_t mk_row(input logic [1:0] cmd, input logic [3:0] idx,
                                  input logic [31:0] src, input logic [31:0] dst,
                                  input logic [7:0] proto, input logic [15:0] kind,
                                  input logic [2:0] wild, input logic [1:0] act,
                                  input logic typed, input logic drop,
                                  input logic [31:0] total);
    row_t w;
    w.rq.cmd   = cmd;
    w.rq.idx   = idx;
    w.rq.src   = src;
    w.rq.dst   = dst;
    w.rq.proto = proto;
    w.rq.kind  = kind;
    w.rq.s_any = wild[0];
    w.rq.d_any = wild[1];
    w.rq.p_any = wild[2];
    w.rq.act   = act;
    w.typed    = typed;
    w.want     = {drop, total};
    return w;
  endfunction

  // Keeps the sender's view of the rule table up to date.
  task automatic note_request(input req_t r);
    if (r.cmd == awdf_pkg::CMD_WRITE) begin
      plan_written[r.idx] = 1'b1;
      plan_live[r.idx]    = 1'b0;
      plan_src[r.idx]     = r.src;
      plan_dst[r.idx]     = r.dst;
      plan_proto[r.idx]   = r.proto;
      plan_wild[r.idx]    = {r.p_any, r.d_any, r.s_any};
    end else if (r.cmd == awdf_pkg::CMD_ACTIVATE) begin
      plan_live[r.idx] = 1'b1;
    end
  endtask

  // Sends one request after a random gap and returns at its accepting edge.
  task automatic push_req(input req_t r, input logic typed, input verdict_t want);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, r.act, r.p_any, r.d_any, r.s_any, r.kind, r.proto,
                  r.dst, r.src, r.idx};
    in_tuser  <= r.cmd;
    cur_req   <= r;
    cur_typed <= typed;
    cur_want  <= want;
    note_request(r);
    do @(posedge clk); while (!in_tready);
  endtask

  // Draws one random request. Packets mostly aim at live rules, with some
  // near misses; slots are only activated once they have been written.
  task automatic draw_request(output req_t r);
    int unsigned roll;
    logic [3:0]  k;
    logic [3:0]  pick;
    logic        found;
    r     = '0;
    roll  = $urandom_range(0, 99);
    found = 1'b0;
    pick  = '0;
    if (roll >= 80 && roll < 95) begin
      for (int t = 0; t < 32; t++) begin
        k = 4'($urandom_range(0, awdf_pkg::RULES - 1));
        if (plan_written[k]) begin
          found = 1'b1;
          pick  = k;
          break;
        end
      end
      if (!found) roll = 70;
    end
    // Fields that the command ignores still get random values.
    r.idx   = 4'($urandom);
    r.src   = $urandom;
    r.dst   = $urandom;
    r.proto = 8'($urandom);
    r.kind  = 16'($urandom);
    r.s_any = 1'($urandom);
    r.d_any = 1'($urandom);
    r.p_any = 1'($urandom);
    r.act   = 2'($urandom);
    if (roll < 62) begin
      r.cmd = awdf_pkg::CMD_CHECK;
      if ($urandom_range(0, 9) < 8) r.kind = awdf_pkg::IPV4_KIND;
      if ($urandom_range(0, 3) != 0) begin
        for (int t = 0; t < 8; t++) begin
          k = 4'($urandom_range(0, awdf_pkg::RULES - 1));
          if (plan_live[k]) begin
            if (!plan_wild[k][0]) r.src = plan_src[k];
            if (!plan_wild[k][1]) r.dst = plan_dst[k];
            if (!plan_wild[k][2]) r.proto = plan_proto[k];
            // A near miss flips one bit of one field.
            if ($urandom_range(0, 3) == 0) begin
              case ($urandom_range(0, 2))
                0:       r.src ^= 32'd1 << $urandom_range(0, 31);
                1:       r.dst ^= 32'd1 << $urandom_range(0, 31);
                default: r.proto ^= 8'd1 << $urandom_range(0, 7);
              endcase
            end
            break;
          end
        end
      end
    end else if (roll < 80) begin
      r.cmd = awdf_pkg::CMD_WRITE;
      if ($urandom_range(0, 1) == 0) r.src = {30'h3_02A_0000, 2'($urandom)};
      if ($urandom_range(0, 1) == 0) r.dst = {30'h0_280_0000, 2'($urandom)};
      if ($urandom_range(0, 1) == 0) r.proto = ($urandom_range(0, 1) == 0) ? 8'd6 : 8'd17;
      r.s_any = ($urandom_range(0, 2) == 0);
      r.d_any = ($urandom_range(0, 2) == 0);
      r.p_any = ($urandom_range(0, 2) == 0);
      r.act   = ($urandom_range(0, 9) < 7) ? awdf_pkg::ACT_DROP : 2'($urandom);
    end else if (roll < 95) begin
      r.cmd = awdf_pkg::CMD_ACTIVATE;
      r.idx = pick;
    end else begin
      r.cmd = CMD_NOP;
    end
  endtask

  // Predicts each accepted request and checks each accepted result.
  always @(posedge clk) begin : score
    verdict_t got;
    verdict_t want;
    verdict_t pred;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[0], out_tdata[32:1]};
        if (exp_rd == exp_wr) begin
          $display("%0t ns: result with no request pending, got drop %0d total %0d",
                   $time, got.drop, got.total);
          fail_count++;
        end else begin
          want   = exp_mem[exp_rd[5:0]];
          exp_rd = exp_rd + 32'd1;
          if (got.drop !== want.drop) begin
            $display("%0t ns: drop mismatch, expected %0d, got %0d",
                     $time, want.drop, got.drop);
            fail_count++;
          end
          if (got.total !== want.total) begin
            $display("%0t ns: dropped_total mismatch, expected %0d, got %0d",
                     $time, want.total, got.total);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        pred.drop  = acl_verdict(cur_req);
        pred.total = drop_total;
        if (cur_typed) pred = cur_want;
        exp_mem[exp_wr[5:0]] = pred;
        exp_wr = exp_wr + 32'd1;
      end
    end
  end

  // Result side: a random stall after each result, with calm stretches.
  always @(posedge clk) begin : sink
    int unsigned stall_left;
    int unsigned seen;
    logic        calm;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      seen       = 0;
      calm       = 1'b0;
    end else if (out_tvalid && out_tready) begin
      seen++;
      if (seen % 97 == 0) calm = ($urandom_range(0, 2) == 0);
      stall_left = calm ? 0 : $urandom_range(0, 7);
      out_tready <= (stall_left == 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_tready <= (stall_left == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    req_t rq;
    for (int k = 0; k < awdf_pkg::RULES; k++) begin
      slot_live[k]    = 1'b0;
      plan_written[k] = 1'b0;
      plan_live[k]    = 1'b0;
    end
    drop_total = '0;

    // Directed rows: cmd, slot, src, dst, proto, kind, wildcards {p,d,s}, action.
    dir_tab[0]  = mk_row(awdf_pkg::CMD_CHECK, '0, '0, '0, '0, awdf_pkg::IPV4_KIND,
                         3'b000, awdf_pkg::ACT_DROP, 1'b1, 1'b0, '0);
    dir_tab[1]  = mk_row(CMD_NOP, 4'd15, '1, '1, '1, '1, 3'b111, ACT_BAD,
                         1'b1, 1'b0, '0);
    dir_tab[2]  = mk_row(awdf_pkg::CMD_WRITE, '0, 32'hC0A8_0001, 32'h0A00_0001, 8'd6, '0,
                         3'b000, awdf_pkg::ACT_DROP, 1'b1, 1'b0, '0);
    dir_tab[3]  = mk_row(awdf_pkg::CMD_CHECK, '0, 32'hC0A8_0001, 32'h0A00_0001, 8'd6,
                         awdf_pkg::IPV4_KIND, 3'b000, awdf_pkg::ACT_DROP,
                         1'b1, 1'b0, '0);
    dir_tab[4]  = mk_row(awdf_pkg::CMD_ACTIVATE, '0, '0, '0, '0, '0, 3'b000,
                         awdf_pkg::ACT_DROP, 1'b1, 1'b0, '0);
    dir_tab[5]  = mk_row(awdf_pkg::CMD_CHECK, '0, 32'hC0A8_0001, 32'h0A00_0001, 8'd6,
                         awdf_pkg::IPV4_KIND, 3'b000, awdf_pkg::ACT_DROP,
                         1'b1, 1'b1, 32'd1);
    // Matching addresses, but not IPv4.
    dir_tab[6]  = mk_row(awdf_pkg::CMD_CHECK, '0, 32'hC0A8_0001, 32'h0A00_0001, 8'd6,
                         16'h86DD, 3'b000, awdf_pkg::ACT_DROP, 1'b1, 1'b0, 32'd1);
    dir_tab[7]  = mk_row(awdf_pkg::CMD_CHECK, '0, 32'hC0A8_0001, 32'h0A00_0001, 8'd17,
                         awdf_pkg::IPV4_KIND, 3'b000, awdf_pkg::ACT_DROP,
                         1'b1, 1'b0, 32'd1);
    dir_tab[8]  = mk_row(awdf_pkg::CMD_CHECK, '0, 32'hC0A8_0001, 32'h0A00_0002, 8'd6,
                         awdf_pkg::IPV4_KIND, 3'b000, awdf_pkg::ACT_DROP,
                         1'b1, 1'b0, 32'd1);
    // Top slot: fixed source, any destination and protocol.
    dir_tab[9]  = mk_row(awdf_pkg::CMD_WRITE, 4'd15, '1, '0, '0, '0, 3'b110,
                         awdf_pkg::ACT_DROP, 1'b1, 1'b0, 32'd1);
    dir_tab[10] = mk_row(awdf_pkg::CMD_ACTIVATE, 4'd15, '0, '0, '0, '0, 3'b000,
                         awdf_pkg::ACT_DROP, 1'b1, 1'b0, 32'd1);
    dir_tab[11] = mk_row(awdf_pkg::CMD_CHECK, '0, '1, 32'h1234_5678, 8'hFF,
                         awdf_pkg::IPV4_KIND, 3'b000, awdf_pkg::ACT_DROP,
                         1'b1, 1'b1, 32'd2);
    // Rules with actions other than drop never drop.
    dir_tab[12] = mk_row(awdf_pkg::CMD_WRITE, 4'd1, '0, '0, '0, '0, 3'b111, ACT_RATE,
                         1'b1, 1'b0, 32'd2);
    dir_tab[13] = mk_row(awdf_pkg::CMD_ACTIVATE, 4'd1, '0, '0, '0, '0, 3'b000,
                         awdf_pkg::ACT_DROP, 1'b1, 1'b0, 32'd2);
    dir_tab[14] = mk_row(awdf_pkg::CMD_CHECK, '0, 32'h1234_5678, 32'h8765_4321, 8'd17,
                         awdf_pkg::IPV4_KIND, 3'b000, awdf_pkg::ACT_DROP,
                         1'b1, 1'b0, 32'd2);
    dir_tab[15] = mk_row(awdf_pkg::CMD_WRITE, 4'd2, '0, '0, '0, '0, 3'b111, ACT_REDIRECT,
                         1'b1, 1'b0, 32'd2);
    dir_tab[16] = mk_row(awdf_pkg::CMD_ACTIVATE, 4'd2, '0, '0, '0, '0, 3'b000,
                         awdf_pkg::ACT_DROP, 1'b1, 1'b0, 32'd2);
    dir_tab[17] = mk_row(awdf_pkg::CMD_CHECK, '0, 32'h1234_5678, 32'h8765_4321, 8'd17,
                         awdf_pkg::IPV4_KIND, 3'b000, awdf_pkg::ACT_DROP,
                         1'b0, 1'b0, '0);
    // Full wildcard drop rule; a packet that also hits the top slot counts once.
    dir_tab[18] = mk_row(awdf_pkg::CMD_WRITE, 4'd3, '0, '0, '0, '0, 3'b111,
                         awdf_pkg::ACT_DROP, 1'b1, 1'b0, 32'd2);
    dir_tab[19] = mk_row(awdf_pkg::CMD_ACTIVATE, 4'd3, '0, '0, '0, '0, 3'b000,
                         awdf_pkg::ACT_DROP, 1'b1, 1'b0, 32'd2);
    dir_tab[20] = mk_row(awdf_pkg::CMD_CHECK, '0, '0, '0, '0, awdf_pkg::IPV4_KIND,
                         3'b000, awdf_pkg::ACT_DROP, 1'b1, 1'b1, 32'd3);
    dir_tab[21] = mk_row(awdf_pkg::CMD_CHECK, '0, '1, '0, '0, awdf_pkg::IPV4_KIND,
                         3'b000, awdf_pkg::ACT_DROP, 1'b1, 1'b1, 32'd4);
    // Rewriting a slot leaves it inactive.
    dir_tab[22] = mk_row(awdf_pkg::CMD_WRITE, 4'd3, '0, '0, '0, '0, 3'b111, ACT_BAD,
                         1'b1, 1'b0, 32'd4);
    dir_tab[23] = mk_row(awdf_pkg::CMD_CHECK, '0, '0, '0, '0, awdf_pkg::IPV4_KIND,
                         3'b000, awdf_pkg::ACT_DROP, 1'b0, 1'b0, '0);
    dir_tab[24] = mk_row(awdf_pkg::CMD_CHECK, '0, '1, '0, '0, 16'h0801, 3'b000,
                         awdf_pkg::ACT_DROP, 1'b1, 1'b0, 32'd4);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      push_req(dir_tab[i].rq, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) sender_calm = ($urandom_range(0, 2) == 0);
      draw_request(rq);
      push_req(rq, 1'b0, '0);
    end
    in_tvalid <= 1'b0;

    // Drain, then leave room for anything stray.
    do @(posedge clk); while (exp_rd != exp_wr);
    repeat (awdf_pkg::RULES + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
